[rtl/core/btsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package btsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 20;
  localparam int COUNT_BITS  = INDEX_BITS + 1;
  localparam int CMD_BITS    = 2;
  localparam int CFG_ADDR_BITS = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [CMD_BITS-1:0]           cmd_t;
  typedef logic [CFG_ADDR_BITS-1:0]      cfg_addr_t;

  // command codes
  localparam cmd_t CMD_RESTART  = 2'd0;
  localparam cmd_t CMD_BASELINE = 2'd1;
  localparam cmd_t CMD_DETECT   = 2'd2;

  // configuration register indexes
  localparam cfg_addr_t REG_WINDOW_FIRST = 2'd0;
  localparam cfg_addr_t REG_WINDOW_LAST  = 2'd1;
  localparam cfg_addr_t REG_REFRACTORY   = 2'd2;

  typedef struct packed {
    index_t window_first;
    index_t window_last;
    index_t refractory_samples;
  } cfg_t;

  typedef struct packed {
    logic    spike;
    sample_t low_mark;
    sample_t high_mark;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/btsd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module btsd_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire btsd_pkg::cfg_addr_t  cfg_index,
  input  wire btsd_pkg::index_t     cfg_data,
  output btsd_pkg::cfg_t            cfg
);

  btsd_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        btsd_pkg::REG_WINDOW_FIRST: regs.window_first       <= cfg_data;
        btsd_pkg::REG_WINDOW_LAST:  regs.window_last        <= cfg_data;
        btsd_pkg::REG_REFRACTORY:   regs.refractory_samples <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[rtl/core/btsd_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module btsd_track (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire btsd_pkg::cmd_t    command,
  input  wire btsd_pkg::sample_t sample,
  input  wire btsd_pkg::cfg_t    cfg,
  output btsd_pkg::result_t      res
);

  btsd_pkg::sample_t low_level, low_level_next;
  btsd_pkg::sample_t high_level, high_level_next;
  btsd_pkg::count_t  baseline_index, baseline_index_next;
  btsd_pkg::count_t  lapse_count, lapse_count_next;

  btsd_pkg::count_t first_ext, last_ext, refr_ext;
  logic             in_window;
  logic             spike;

  always_comb begin
    first_ext = {1'b0, cfg.window_first};
    last_ext  = {1'b0, cfg.window_last};
    refr_ext  = {1'b0, cfg.refractory_samples};
    in_window = (baseline_index >= first_ext) && (baseline_index <= last_ext);

    low_level_next      = low_level;
    high_level_next     = high_level;
    baseline_index_next = baseline_index;
    lapse_count_next    = lapse_count;
    spike               = 1'b0;

    case (command)
      btsd_pkg::CMD_RESTART: begin
        low_level_next      = '0;
        high_level_next     = '0;
        baseline_index_next = '0;
        lapse_count_next    = refr_ext;
      end
      btsd_pkg::CMD_BASELINE: begin
        if (in_window) begin
          if (sample > high_level) high_level_next = sample;
          if (sample < low_level)  low_level_next  = sample;
        end
        // index sticks at all ones, past any window
        if (baseline_index != '1) baseline_index_next = baseline_index + 1'b1;
      end
      btsd_pkg::CMD_DETECT: begin
        if ((sample < low_level) && (lapse_count > refr_ext)) begin
          spike            = 1'b1;
          lapse_count_next = '0;
        end else if (lapse_count != '1) begin
          lapse_count_next = lapse_count + 1'b1;
        end
      end
      default: ;  // unused code: no change
    endcase

    res.spike     = spike;
    res.low_mark  = low_level_next;
    res.high_mark = high_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level      <= '0;
      high_level     <= '0;
      baseline_index <= '0;
      lapse_count    <= '0;
    end else if (step) begin
      low_level      <= low_level_next;
      high_level     <= high_level_next;
      baseline_index <= baseline_index_next;
      lapse_count    <= lapse_count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/baseline_threshold_spike_detector.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_ready    command, sample
// out       out_valid / out_ready  spike, low_mark, high_mark
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; a request
// passes through two registers (input register, then result register). The
// marks, counters and compares all sit between those two registers. Reset
// clears valids, marks, indexes and config. A stalled output holds its result
// while the input register keeps its request; in_ready drops only when both
// are full and out_ready is low. cfg_ready is always high.

module baseline_threshold_spike_detector (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire btsd_pkg::cmd_t       command,
  input  wire btsd_pkg::sample_t    sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      spike,
  output btsd_pkg::sample_t         low_mark,
  output btsd_pkg::sample_t         high_mark,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire btsd_pkg::cfg_addr_t  cfg_index,
  input  wire btsd_pkg::index_t     cfg_data
);

  btsd_pkg::cfg_t    cfg;
  btsd_pkg::result_t res;

  // input register
  logic              in_held;
  btsd_pkg::cmd_t    command_q;
  btsd_pkg::sample_t sample_q;

  logic out_free;
  logic advance;
  logic take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = in_held && out_free;   // input register -> result
  assign in_ready  = !in_held || out_free;
  assign take      = in_valid && in_ready;

  btsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btsd_track u_track (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .command (command_q),
    .sample  (sample_q),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (take) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      command_q <= command;
      sample_q  <= sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      spike     <= res.spike;
      low_mark  <= res.low_mark;
      high_mark <= res.high_mark;
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  // The package names three commands; the fourth code must leave all state
  // alone and still answer with the current marks.
  localparam btsd_pkg::cmd_t    CMD_UNUSED = 2'd3;
  localparam btsd_pkg::sample_t SAMPLE_MIN = 16'sh8000;
  localparam btsd_pkg::sample_t SAMPLE_MAX = 16'sh7fff;
  localparam btsd_pkg::index_t  INDEX_TOP  = 20'hfffff;

  // Scoreboard: keeps its own copy of the marks, the baseline index, the
  // lapse counter and the three registers. Every accepted request produces
  // exactly one expected result, queued in order.
  class spike_scoreboard;
    btsd_pkg::index_t  window_first   = '0;
    btsd_pkg::index_t  window_last    = '0;
    btsd_pkg::index_t  refractory     = '0;
    btsd_pkg::sample_t low_level      = '0;
    btsd_pkg::sample_t high_level     = '0;
    btsd_pkg::count_t  baseline_index = '0;
    btsd_pkg::count_t  lapse_count    = '0;
    btsd_pkg::result_t expected_q[$];
    int unsigned mismatches = 0;

    function void apply_register(btsd_pkg::cfg_addr_t idx, btsd_pkg::index_t data);
      case (idx)
        btsd_pkg::REG_WINDOW_FIRST: window_first = data;
        btsd_pkg::REG_WINDOW_LAST:  window_last  = data;
        btsd_pkg::REG_REFRACTORY:   refractory   = data;
        default: ;
      endcase
    endfunction

    function void note_request(btsd_pkg::cmd_t cmd, btsd_pkg::sample_t smp);
      btsd_pkg::result_t want;
      want.spike = 1'b0;
      case (cmd)
        btsd_pkg::CMD_RESTART: begin
          low_level      = '0;
          high_level     = '0;
          baseline_index = '0;
          lapse_count    = btsd_pkg::count_t'(refractory);
        end
        btsd_pkg::CMD_BASELINE: begin
          // only samples inside the index window widen the marks
          if (baseline_index >= btsd_pkg::count_t'(window_first) &&
              baseline_index <= btsd_pkg::count_t'(window_last)) begin
            if (smp > high_level) high_level = smp;
            if (smp < low_level) low_level = smp;
          end
          if (baseline_index != '1) baseline_index++;
        end
        btsd_pkg::CMD_DETECT: begin
          // strictly below the low mark and strictly past the refractory count
          if (smp < low_level && lapse_count > btsd_pkg::count_t'(refractory)) begin
            want.spike  = 1'b1;
            lapse_count = '0;
          end else if (lapse_count != '1) begin
            lapse_count++;
          end
        end
        default: ;
      endcase
      want.low_mark  = low_level;
      want.high_mark = high_level;
      expected_q = {expected_q, want};
    endfunction

    function void check_result(logic spike, btsd_pkg::sample_t lo, btsd_pkg::sample_t hi);
      btsd_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding (spike %0b low %0d high %0d)",
                   $time, spike, lo, hi);
        return;
      end
      want = expected_q.pop_front();
      if (want.spike !== spike || want.low_mark !== lo || want.high_mark !== hi) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp spike %0b low %0d high %0d, got spike %0b low %0d high %0d",
                   $time, want.spike, want.low_mark, want.high_mark, spike, lo, hi);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  btsd_pkg::cmd_t      command   = btsd_pkg::CMD_RESTART;
  btsd_pkg::sample_t   sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                spike;
  btsd_pkg::sample_t   low_mark;
  btsd_pkg::sample_t   high_mark;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  btsd_pkg::cfg_addr_t cfg_index = btsd_pkg::REG_WINDOW_FIRST;
  btsd_pkg::index_t    cfg_data  = '0;

  spike_scoreboard sb = new;

  // Sender burst bookkeeping and the one-shot long receiver stall.
  int unsigned burst_left   = 5;
  bit          hold_pending = 1'b0;

  always #10 clk = ~clk;

  baseline_threshold_spike_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .spike     (spike),
    .low_mark  (low_mark),
    .high_mark (high_mark),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Monitor: all handshakes are observed at the rising edge. Inputs only move
  // on the falling edge, so nothing here races the drivers. A request and a
  // result on the same edge are unrelated (the result is registered), so order is free.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(command, sample);
      if (out_valid && out_ready) sb.check_result(spike, low_mark, high_mark);
    end
  end

  // Receiver: segments of random length, each with its own ready pattern.
  // A pending long hold drops ready so the two internal registers fill and
  // in_ready must fall.
  initial begin
    int unsigned mode;
    int unsigned seg;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        @(negedge clk);
        if (hold_pending) begin
          out_ready <= 1'b0;
          repeat (120) @(negedge clk);
          hold_pending = 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Drop valid for a pause whose length n the caller picks.
  task automatic pause(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Offer one request and hold it until accepted; at the end of a burst the
  // sender goes quiet for a while. Zero-length gaps keep valid high across
  // bursts, and the occasional long burst gives stretches with no idling.
  task automatic send_item(btsd_pkg::cmd_t c, btsd_pkg::sample_t s);
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= c;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic write_cfg(btsd_pkg::cfg_addr_t idx, btsd_pkg::index_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request has produced its result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(btsd_pkg::index_t first, btsd_pkg::index_t last,
                               btsd_pkg::index_t refr);
    settle();
    write_cfg(btsd_pkg::REG_WINDOW_FIRST, first);
    write_cfg(btsd_pkg::REG_WINDOW_LAST, last);
    write_cfg(btsd_pkg::REG_REFRACTORY, refr);
  endtask

  // 0: full range, 1: small noise around zero, else: an extreme or one of -1, 0, 1
  function automatic btsd_pkg::sample_t pick_sample(int unsigned kind);
    case (kind)
      0: return btsd_pkg::sample_t'($urandom);
      1: return btsd_pkg::sample_t'(int'($urandom_range(0, 511)) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return -16'sd1;
          3: return 16'sd0;
          default: return 16'sd1;
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed recordings: restart, a baseline pass, then a detect
  // pass with a little baseline and unused-command noise mixed in. The rest
  // is raw noise over all four command codes.
  task automatic run_phase(int unsigned quota);
    int unsigned n;
    int unsigned base_len;
    int unsigned det_len;
    int unsigned base_kind;
    n = 0;
    while (n < quota) begin
      if ($urandom_range(0, 9) < 8) begin
        // skipping the restart now and then keeps stale marks and counters
        if ($urandom_range(0, 7) != 0) begin
          send_item(btsd_pkg::CMD_RESTART, btsd_pkg::sample_t'($urandom));
          n++;
        end
        base_len  = $urandom_range(0, 40);
        base_kind = $urandom_range(0, 2);
        repeat (base_len) begin
          send_item(btsd_pkg::CMD_BASELINE, pick_sample(base_kind));
          n++;
        end
        det_len = $urandom_range(1, 60);
        repeat (det_len) begin
          case ($urandom_range(0, 31))
            0:    send_item(CMD_UNUSED, btsd_pkg::sample_t'($urandom));
            1, 2: send_item(btsd_pkg::CMD_BASELINE, pick_sample($urandom_range(0, 2)));
            // mostly quiet signal with occasional large excursions
            default: send_item(btsd_pkg::CMD_DETECT,
                               pick_sample(($urandom_range(0, 4) == 0) ? 0 :
                                           ($urandom_range(0, 9) == 0) ? 2 : 1));
          endcase
          n++;
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send_item(btsd_pkg::cmd_t'($urandom_range(0, 3)),
                    btsd_pkg::sample_t'($urandom));
          n++;
        end
      end
    end
  endtask

  initial begin
    btsd_pkg::index_t wf;
    btsd_pkg::index_t wl;
    btsd_pkg::index_t rf;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: window covers baseline indexes 2..5, refractory of 3.
    write_cfg(btsd_pkg::REG_WINDOW_FIRST, 20'd2);
    write_cfg(btsd_pkg::REG_WINDOW_LAST, 20'd5);
    write_cfg(btsd_pkg::REG_REFRACTORY, 20'd3);

    // Detect with no restart: counter starts at zero, so only the fifth
    // dip below the zero mark may fire.
    repeat (5) send_item(btsd_pkg::CMD_DETECT, SAMPLE_MIN);
    send_item(CMD_UNUSED, SAMPLE_MAX);
    send_item(btsd_pkg::CMD_RESTART, 16'sd12345);
    // indexes 0 and 1 fall before the window and must not move the marks
    send_item(btsd_pkg::CMD_BASELINE, SAMPLE_MAX);
    send_item(btsd_pkg::CMD_BASELINE, SAMPLE_MIN);
    send_item(btsd_pkg::CMD_BASELINE, 16'sd100);
    send_item(btsd_pkg::CMD_BASELINE, -16'sd100);
    send_item(btsd_pkg::CMD_BASELINE, SAMPLE_MAX);
    send_item(btsd_pkg::CMD_BASELINE, -16'sd1);
    // past the window again
    send_item(btsd_pkg::CMD_BASELINE, SAMPLE_MIN);
    send_item(btsd_pkg::CMD_BASELINE, 16'sd0);
    // equal to the low mark is not a spike; one below is
    send_item(btsd_pkg::CMD_DETECT, -16'sd100);
    send_item(btsd_pkg::CMD_DETECT, -16'sd101);
    send_item(btsd_pkg::CMD_DETECT, SAMPLE_MIN);
    // baseline after detect: outside the window, lapse count untouched
    send_item(btsd_pkg::CMD_BASELINE, -16'sd200);
    send_item(btsd_pkg::CMD_DETECT, SAMPLE_MAX);
    send_item(btsd_pkg::CMD_DETECT, SAMPLE_MIN);
    send_item(btsd_pkg::CMD_DETECT, SAMPLE_MIN);
    send_item(CMD_UNUSED, SAMPLE_MIN);

    // Random part, one register setting per phase, extremes first.
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin wf = '0;        wl = '0;        rf = '0;        end
        1: begin wf = INDEX_TOP; wl = INDEX_TOP; rf = INDEX_TOP; end
        2: begin wf = 20'd12;    wl = 20'd3;     rf = 20'd5;     end  // empty window
        3: begin wf = '0;        wl = INDEX_TOP; rf = '0;        end
        default: begin
          wf = btsd_pkg::index_t'($urandom_range(0, 16));
          wl = wf + btsd_pkg::index_t'($urandom_range(0, 40));
          rf = btsd_pkg::index_t'($urandom_range(0, 40));
        end
      endcase
      load_settings(wf, wl, rf);
      // long receiver stall while the sender keeps pushing
      if (p == 0) hold_pending = 1'b1;
      run_phase(150);
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
